### hw/rtl/mbm_pkg.sv
package mbm_pkg;

   // Transaction kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_RESET = 2'd2
   } kind_type;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned CYCLE_W  = 8;
   localparam int unsigned BANK_W   = 6;
   localparam int unsigned SEL_W    = 3;
   localparam int unsigned GAME_W   = 2;
   localparam int unsigned COUNT_W  = 16;

   // Register decode masks and match values.
   localparam logic [ADDR_W-1:0] ADDR_REG_BASE   = 16'h4020;
   localparam logic [ADDR_W-1:0] INNER_MASK      = 16'h71FF;
   localparam logic [ADDR_W-1:0] INNER_MATCH     = 16'h4022;
   localparam logic [ADDR_W-1:0] MODE_MATCH      = 16'h4120;
   localparam logic [ADDR_W-1:0] IRQ_MASK        = 16'hF1FF;
   localparam logic [ADDR_W-1:0] IRQ_MATCH       = 16'h4122;
   localparam logic [COUNT_W-1:0] IRQ_TRIGGER_BIT = 16'h1000;
   localparam logic [ADDR_W-1:0] UNROM_SEL_BIT   = 16'h8000;

   localparam logic [SEL_W-1:0]  INNER_RESET     = 3'd3;
   localparam logic [GAME_W-1:0] GAME_MULTI_8K   = 2'd0;
   localparam logic [GAME_W-1:0] GAME_HMIRROR    = 2'd3;

   // Game 0 window at 0xC000: row chosen by mode bit, column by inner select.
   localparam logic [BANK_W-1:0] C000_ROW0 [8] =
      '{6'd4, 6'd3, 6'd5, 6'd3, 6'd6, 6'd3, 6'd7, 6'd3};
   localparam logic [BANK_W-1:0] C000_ROW1 [8] =
      '{6'd1, 6'd1, 6'd5, 6'd1, 6'd4, 6'd1, 6'd5, 6'd1};

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  address;
      logic [DATA_W-1:0]  write_data;
      logic [CYCLE_W-1:0] cycles;
   } req_item_type;

   typedef struct packed {
      logic [BANK_W-1:0] bank_6000;
      logic              window_6000_mapped;
      logic [BANK_W-1:0] bank_8000;
      logic [BANK_W-1:0] bank_a000;
      logic [BANK_W-1:0] bank_c000;
      logic [BANK_W-1:0] bank_e000;
      logic              horizontal_mirror;
      logic              irq_line;
   } rsp_item_type;

   typedef struct packed {
      logic [SEL_W-1:0]   inner_select;
      logic               mode_bit;
      logic [SEL_W-1:0]   unrom_bank;
      logic               irq_enable;
      logic [COUNT_W-1:0] irq_counter;
      logic               irq_latched;
      logic [GAME_W-1:0]  game_select;
   } state_type;

   function automatic logic [BANK_W-1:0] c000_lookup(input logic mode,
                                                      input logic [SEL_W-1:0] sel);
      logic [BANK_W-1:0] val;
      if (mode) begin
         val = C000_ROW1[sel];
      end else begin
         val = C000_ROW0[sel];
      end
      return val;
   endfunction

endpackage

### hw/rtl/mbm_if.sv
interface mbm_req_if;
   logic                         valid;
   logic                         ready;
   logic [mbm_pkg::KIND_W-1:0]   kind;
   logic [mbm_pkg::ADDR_W-1:0]   address;
   logic [mbm_pkg::DATA_W-1:0]   write_data;
   logic [mbm_pkg::CYCLE_W-1:0]  cycles;

   modport source (output valid, output kind, output address, output write_data,
                   output cycles, input ready);
   modport sink   (input valid, input kind, input address, input write_data,
                   input cycles, output ready);
endinterface

interface mbm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mbm_pkg::BANK_W-1:0]  bank_6000;
   logic                        window_6000_mapped;
   logic [mbm_pkg::BANK_W-1:0]  bank_8000;
   logic [mbm_pkg::BANK_W-1:0]  bank_a000;
   logic [mbm_pkg::BANK_W-1:0]  bank_c000;
   logic [mbm_pkg::BANK_W-1:0]  bank_e000;
   logic                        horizontal_mirror;
   logic                        irq_line;

   modport source (output valid, output bank_6000, output window_6000_mapped,
                   output bank_8000, output bank_a000, output bank_c000,
                   output bank_e000, output horizontal_mirror, output irq_line,
                   input ready);
   modport sink   (input valid, input bank_6000, input window_6000_mapped,
                   input bank_8000, input bank_a000, input bank_c000,
                   input bank_e000, input horizontal_mirror, input irq_line,
                   output ready);
endinterface

### hw/rtl/mbm_regs.sv
module mbm_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mbm_pkg::req_item_type item,
   output mbm_pkg::state_type    state_in
);
   import mbm_pkg::*;

   state_type          state_ff;
   logic               addr_ok;
   logic [COUNT_W-1:0] count_sum;

   assign addr_ok   = (item.address >= ADDR_REG_BASE);
   assign count_sum = state_ff.irq_counter + COUNT_W'(item.cycles);

   // Every matching decode of a write applies.
   always_comb begin
      state_in = state_ff;
      case (item.kind)
         KIND_WRITE: begin
            if (addr_ok) begin
               if ((item.address & UNROM_SEL_BIT) != '0) begin
                  state_in.unrom_bank = item.write_data[SEL_W-1:0];
               end
               if ((item.address & INNER_MASK) == INNER_MATCH) begin
                  state_in.inner_select = item.write_data[SEL_W-1:0];
               end
               if ((item.address & INNER_MASK) == MODE_MATCH) begin
                  state_in.mode_bit = item.write_data[0];
               end
               if ((item.address & IRQ_MASK) == IRQ_MATCH) begin
                  state_in.irq_enable  = item.write_data[0];
                  state_in.irq_counter = '0;
                  state_in.irq_latched = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            if (state_ff.irq_enable) begin
               state_in.irq_counter = count_sum;
               if ((count_sum & IRQ_TRIGGER_BIT) != '0) begin
                  state_in.irq_latched = 1'b1;
               end
            end
         end
         KIND_RESET: begin
            state_in.inner_select = INNER_RESET;
            state_in.mode_bit     = 1'b0;
            state_in.unrom_bank   = '0;
            state_in.irq_enable   = 1'b0;
            state_in.irq_counter  = '0;
            state_in.irq_latched  = 1'b0;
            state_in.game_select  = state_ff.game_select + GAME_W'(1);
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.inner_select <= INNER_RESET;
         state_ff.mode_bit     <= 1'b0;
         state_ff.unrom_bank   <= '0;
         state_ff.irq_enable   <= 1'b0;
         state_ff.irq_counter  <= '0;
         state_ff.irq_latched  <= 1'b0;
         state_ff.game_select  <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/mbm_map.sv
module mbm_map (
   input  mbm_pkg::state_type    st,
   output mbm_pkg::rsp_item_type res
);
   import mbm_pkg::*;

   logic [GAME_W-1:0] g;
   logic              m;

   assign g = st.game_select;
   assign m = st.mode_bit;

   always_comb begin
      res.horizontal_mirror = (g == GAME_HMIRROR);
      res.irq_line          = st.irq_latched;
      if (g == GAME_MULTI_8K) begin
         res.bank_6000          = m ? 6'd0 : 6'd2;
         res.window_6000_mapped = 1'b1;
         res.bank_8000          = m ? 6'd0 : 6'd1;
         res.bank_a000          = '0;
         res.bank_c000          = c000_lookup(m, st.inner_select);
         res.bank_e000          = m ? 6'd8 : 6'd10;
      end else begin
         // 16 KB bank {game, bank} split into two 8 KB halves.
         res.bank_6000          = '0;
         res.window_6000_mapped = 1'b0;
         res.bank_8000          = {g, st.unrom_bank, 1'b0};
         res.bank_a000          = {g, st.unrom_bank, 1'b1};
         res.bank_c000          = {g, 3'b111, 1'b0};
         res.bank_e000          = {g, 3'b111, 1'b1};
      end
   end

endmodule

### hw/rtl/multicart_bank_mapper_irq.sv
// Bank mapper with CPU-cycle IRQ counter for a four-game multicart.
// The request channel carries one transaction per CPU write, cycle tick or
// console reset; the response channel returns one transaction per request with
// the five 8 KB PRG bank numbers, the 0x6000 window flag, mirroring and the
// IRQ line, all reflecting the mapper state after that request.
// The request register captures the transaction when it is accepted; when the
// response stage advances, the state update and bank decode land together in
// the response register.
// Throughput is one transaction per cycle while the receiver keeps taking
// responses, bounded otherwise only by the state update loop.
// When the receiver stalls, the response register holds its transaction and the
// request register can still take one more; after that, request ready drops
// until the response is taken. No transaction is dropped or repeated.
// The reset input clears both pipeline stages, restores the mapper registers to
// their power-on values and selects game 0. A console-reset transaction clears
// the registers too but advances the game selection instead.
module multicart_bank_mapper_irq (
   input logic         clock,
   input logic         reset,
   mbm_req_if.sink     req_bus,
   mbm_rsp_if.source   rsp_bus
);
   import mbm_pkg::*;

   logic         req_valid_ff;
   req_item_type req_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   state_type    state_in;
   logic         advance;
   logic         req_take;

   // The response stage moves whenever it is empty or being drained.
   assign advance        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !req_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.kind       <= req_bus.kind;
         req_item_ff.address    <= req_bus.address;
         req_item_ff.write_data <= req_bus.write_data;
         req_item_ff.cycles     <= req_bus.cycles;
      end
   end

   // The mapper state commits at the same edge the response is captured.
   mbm_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .step     (req_valid_ff && advance),
      .item     (req_item_ff),
      .state_in (state_in)
   );

   mbm_map u_map (
      .st  (state_in),
      .res (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.bank_6000          = rsp_item_ff.bank_6000;
   assign rsp_bus.window_6000_mapped = rsp_item_ff.window_6000_mapped;
   assign rsp_bus.bank_8000          = rsp_item_ff.bank_8000;
   assign rsp_bus.bank_a000          = rsp_item_ff.bank_a000;
   assign rsp_bus.bank_c000          = rsp_item_ff.bank_c000;
   assign rsp_bus.bank_e000          = rsp_item_ff.bank_e000;
   assign rsp_bus.horizontal_mirror  = rsp_item_ff.horizontal_mirror;
   assign rsp_bus.irq_line           = rsp_item_ff.irq_line;

endmodule
